// File: rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int NPC_ENTRIES  = 256;
    localparam int CHAN_W       = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int ENTRY_W      = CHAN_W * NUM_CHANNELS;
    localparam int SQ_W         = 2 * CHAN_W;
    localparam int DIST_W       = SQ_W + 2;
    localparam int COUNT_W      = 9;
    localparam int INDEX_W      = 8;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// File: rtl/nearest_palette_color_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Finds the palette entry nearest to an RGB pixel by squared distance.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries load words and map words.
// A load word writes one palette slot; a slot at or beyond PALETTE_ENTRIES
// is dropped. A map word starts a scan of entries 0 to N-1, where N is the
// color count register saturated to PALETTE_ENTRIES.
// The scan reads one palette entry per cycle from the RAM and feeds a shared
// distance unit (absolute differences and squares, then sum and compare);
// the palette RAM read port sets that rate. A map word keeps the input
// stalled until its result is loaded into the output register. The result
// word appears on the output channel (o_out_valid / i_out_stall) from a
// register; the next word can be accepted while that result is still
// waiting. A scan that finishes while the previous result is stalled waits
// for the register to free up.
// Ties go to the lowest index; with a count of zero the result is index 0.
// Reset clears the count and the control state; the palette itself is not
// cleared and must be loaded before it is scanned.
// ----------------------------------------------------------------------------
module nearest_palette_color_core
    import npc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = NPC_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_entry_index,
    input  logic [CHAN_W-1:0]  i_red,
    input  logic [CHAN_W-1:0]  i_green,
    input  logic [CHAN_W-1:0]  i_blue,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [INDEX_W-1:0] o_color_index
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    t_state r_state, n_state;

    logic [COUNT_W-1:0] r_color_count;
    logic [CW-1:0]      r_addr;
    logic [CW-1:0]      r_lim;
    logic [CW-1:0]      n_lim;
    logic [ENTRY_W-1:0] r_pix;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;
    logic               r_sq_vld;
    logic [AW-1:0]      r_sq_idx;
    logic [SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0]  r_best_dist;
    logic [AW-1:0]      r_best_idx;
    logic               r_out_vld;
    logic [INDEX_W-1:0] r_out_idx;

    logic               accept;
    logic               rd_en;
    logic               last_issue;
    logic               out_free;
    logic               out_load;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_data;
    logic [CHAN_W-1:0]  d_r, d_g, d_b;
    logic [DIST_W-1:0]  sq_sum;

    npc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Scan length: the count register saturated to the palette depth.
    assign n_lim = (LW'(r_color_count) > LW'(PALETTE_ENTRIES))
                   ? CW'(PALETTE_ENTRIES) : CW'(r_color_count);

    assign last_issue = ((r_addr + CW'(1)) == r_lim);
    assign out_free   = !r_out_vld || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_req_type == REQ_MAP) begin
                    n_state = (n_lim == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_rd_vld && !r_sq_vld && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_SCAN: rd_en      = 1'b1;
            ST_DONE: out_load   = !r_rd_vld && !r_sq_vld && out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;
    assign wr_en  = accept && (i_req_type == REQ_LOAD)
                    && (32'(i_entry_index) < PALETTE_ENTRIES);

    // Distance unit, stage one: absolute channel differences and squares.
    always_comb begin
        logic [CHAN_W-1:0] p_r, p_g, p_b, e_r, e_g, e_b;
        {p_r, p_g, p_b} = r_pix;
        {e_r, e_g, e_b} = rd_data;
        d_r = (p_r >= e_r) ? (p_r - e_r) : (e_r - p_r);
        d_g = (p_g >= e_g) ? (p_g - e_g) : (e_g - p_g);
        d_b = (p_b >= e_b) ? (p_b - e_b) : (e_b - p_b);
    end

    // Stage two: sum of squares.
    assign sq_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_color_count <= '0;
            r_rd_vld      <= 1'b0;
            r_sq_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_sq_vld <= r_rd_vld;
            if (i_cfg_we) begin
                r_color_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req_type == REQ_MAP) begin
            r_pix       <= {i_red, i_green, i_blue};
            r_lim       <= n_lim;
            r_addr      <= '0;
            r_best_dist <= '1;
            r_best_idx  <= '0;
        end else begin
            if (rd_en) begin
                r_addr <= r_addr + CW'(1);
            end
            // Strict compare in index order keeps the lowest index on a tie.
            if (r_sq_vld && sq_sum < r_best_dist) begin
                r_best_dist <= sq_sum;
                r_best_idx  <= r_sq_idx;
            end
        end
        r_rd_idx <= r_addr[AW-1:0];
        r_sq_idx <= r_rd_idx;
        r_sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g   <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b   <= SQ_W'(d_b) * SQ_W'(d_b);
        if (out_load) begin
            r_out_idx <= INDEX_W'(r_best_idx);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_color_index = r_out_idx;

`ifndef SYNTHESIS
    a_sq_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> (CW'(r_sq_idx) < r_lim))
        else $error("distance stage holds an entry beyond the scan length");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_DONE))
        else $error("result word loaded outside the done state");

    a_no_load_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (r_rd_vld || r_sq_vld)) |=> (r_state == ST_DONE))
        else $error("scan finished before the distance pipeline drained");
`endif

endmodule

// File: rtl/npc_ram.sv
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_palette_color_core. A short table of
// directed words covers the not-prepared case, exact hits, ties and extreme
// colors. Random phases follow, each with its own color count, including
// zero and values above the palette size. Every map word is predicted from
// a local copy of the palette, and results are compared in order.
// ----------------------------------------------------------------------------
module testbench;
    import npc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        DIR_LOAD,
        DIR_MAP,
        DIR_CFG
    } t_dir_kind;

    typedef struct packed {
        t_dir_kind          kind;
        logic [7:0]         slot;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic               typed;
        logic [INDEX_W-1:0] want;
        logic [COUNT_W-1:0] count;
    } t_dir_row;

    // A row with typed set carries its own expected index.
    localparam t_dir_row DIRECTED [23] = '{
        '{DIR_MAP,  8'd7,   8'd12,  8'd34,  8'd56,  1'b1, 8'd0, 9'd0},
        '{DIR_MAP,  8'd200, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd1,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd2,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd3,   8'd255, 8'd0,   8'd0,   1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd4,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd5,   8'd0,   8'd0,   8'd255, 1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd255, 8'd170, 8'd85,  8'd170, 1'b0, 8'd0, 9'd0},
        '{DIR_CFG,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 9'd6},
        '{DIR_MAP,  8'd85,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 9'd0},
        '{DIR_MAP,  8'd170, 8'd255, 8'd255, 8'd255, 1'b1, 8'd1, 9'd0},
        '{DIR_MAP,  8'd1,   8'd250, 8'd5,   8'd0,   1'b1, 8'd3, 9'd0},
        '{DIR_MAP,  8'd2,   8'd0,   8'd255, 8'd0,   1'b1, 8'd4, 9'd0},
        '{DIR_MAP,  8'd4,   8'd0,   8'd0,   8'd255, 1'b1, 8'd5, 9'd0},
        '{DIR_MAP,  8'd8,   8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 9'd0},
        '{DIR_LOAD, 8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 9'd0},
        '{DIR_MAP,  8'd16,  8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 9'd0},
        '{DIR_CFG,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 9'd1},
        '{DIR_MAP,  8'd32,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0, 9'd0},
        '{DIR_MAP,  8'd64,  8'd90,  8'd200, 8'd17,  1'b0, 8'd0, 9'd0},
        '{DIR_CFG,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 9'd0},
        '{DIR_MAP,  8'd128, 8'd1,   8'd2,   8'd3,   1'b1, 8'd0, 9'd0}
    };

    localparam int PHASES          = 30;
    localparam int WORDS_PER_PHASE = 50;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_we       = 1'b0;
    logic [COUNT_W-1:0] cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               req_type     = REQ_LOAD;
    logic [7:0]         entry_index  = '0;
    logic [CHAN_W-1:0]  red          = '0;
    logic [CHAN_W-1:0]  green        = '0;
    logic [CHAN_W-1:0]  blue         = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [INDEX_W-1:0] color_index;

    int sender_idle_pct    = 21;
    int receiver_stall_pct = 66;
    int errors             = 0;

    // Local copy of the palette and the count, updated as words are accepted.
    logic [ENTRY_W-1:0] palette_copy [NPC_ENTRIES];
    logic [COUNT_W-1:0] active_count = '0;
    bit                 slot_loaded [NPC_ENTRIES];
    logic [INDEX_W-1:0] pending_indices [$];

    nearest_palette_color_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_entry_index (entry_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_color_index (color_index)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    function automatic logic [INDEX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                                         input logic [CHAN_W-1:0] g,
                                                         input logic [CHAN_W-1:0] b);
        int                 scan_len;
        int                 e;
        int                 dr;
        int                 dg;
        int                 db;
        int unsigned        sum_sq;
        int unsigned        best_dist;
        logic [INDEX_W-1:0] best;
        scan_len  = (active_count > NPC_ENTRIES) ? NPC_ENTRIES : int'(active_count);
        best_dist = 32'hFFFF_FFFF;
        best      = '0;
        for (e = 0; e < scan_len; e++) begin
            dr     = int'(r) - int'(palette_copy[e][23:16]);
            dg     = int'(g) - int'(palette_copy[e][15:8]);
            db     = int'(b) - int'(palette_copy[e][7:0]);
            sum_sq = dr * dr + dg * dg + db * db;
            if (sum_sq < best_dist) begin
                best_dist = sum_sq;
                best      = e[INDEX_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] random_color();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // Returns at the edge where the word is accepted.
    task automatic send_word(input logic req, input logic [7:0] slot,
                             input logic [ENTRY_W-1:0] color,
                             input logic typed, input logic [INDEX_W-1:0] want);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        entry_index <= slot;
        red         <= color[23:16];
        green       <= color[15:8];
        blue        <= color[7:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (req == REQ_LOAD) begin
            palette_copy[slot] = color;
        end else begin
            pending_indices.push_back(typed ? want
                                            : nearest_entry(color[23:16], color[15:8],
                                                            color[7:0]));
        end
    endtask

    // The count only changes with the block idle: drain results, then let a
    // trailing load word finish.
    task automatic write_color_count(input logic [COUNT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        active_count  = value;
    endtask

    always @(posedge clk) begin : result_check
        logic [INDEX_W-1:0] want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_indices.size() == 0) begin
                $display("%0t: color index expected nothing, actual %0d", $time,
                         color_index);
                errors++;
            end else begin
                want = pending_indices.pop_front();
                if (color_index !== want) begin
                    $display("%0t: color index expected %0d, actual %0d", $time, want,
                             color_index);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int                 row;
        int                 phase;
        int                 n;
        int                 k;
        int                 j;
        int                 scan_len;
        logic [COUNT_W-1:0] next_count;
        logic [ENTRY_W-1:0] color;
        logic [7:0]         slot;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < 23; row++) begin
            case (DIRECTED[row].kind)
                DIR_CFG: write_color_count(DIRECTED[row].count);
                DIR_LOAD: begin
                    slot_loaded[DIRECTED[row].slot] = 1'b1;
                    send_word(REQ_LOAD, DIRECTED[row].slot,
                              {DIRECTED[row].red, DIRECTED[row].green, DIRECTED[row].blue},
                              1'b0, '0);
                end
                default: send_word(REQ_MAP, DIRECTED[row].slot,
                                   {DIRECTED[row].red, DIRECTED[row].green,
                                    DIRECTED[row].blue},
                                   DIRECTED[row].typed, DIRECTED[row].want);
            endcase
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES / 3) begin
                sender_idle_pct    = 66;
                receiver_stall_pct = 21;
            end else if (phase == 2 * PHASES / 3) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            case (phase)
                0: next_count = 9'd511;
                1: next_count = 9'd256;
                2: next_count = 9'd0;
                3: next_count = 9'd1;
                default: begin
                    case ($urandom_range(0, 19))
                        0: next_count = 9'd0;
                        1: next_count = 9'd256;
                        2: next_count = 9'($urandom_range(257, 511));
                        3: next_count = 9'd255;
                        default: next_count = 9'($urandom_range(1, 32));
                    endcase
                end
            endcase
            write_color_count(next_count);
            scan_len = (next_count > NPC_ENTRIES) ? NPC_ENTRIES : int'(next_count);

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    // Every entry the scan will touch must be loaded first.
                    for (k = 0; k < scan_len; k++) begin
                        if (!slot_loaded[k]) begin
                            slot_loaded[k] = 1'b1;
                            send_word(REQ_LOAD, 8'(k), random_color(), 1'b0, '0);
                        end
                    end
                    if (scan_len > 0 && $urandom_range(0, 3) == 0)
                        color = palette_copy[$urandom_range(0, scan_len - 1)];
                    else
                        color = random_color();
                    send_word(REQ_MAP, 8'($urandom_range(0, 255)), color, 1'b0, '0);
                end else begin
                    if (scan_len > 0 && $urandom_range(0, 1) == 0)
                        slot = 8'($urandom_range(0, scan_len - 1));
                    else
                        slot = 8'($urandom_range(0, 255));
                    // Copying another entry now and then sets up ties.
                    j = $urandom_range(0, NPC_ENTRIES - 1);
                    if (slot_loaded[j] && $urandom_range(0, 3) == 0)
                        color = palette_copy[j];
                    else
                        color = random_color();
                    slot_loaded[slot] = 1'b1;
                    send_word(REQ_LOAD, slot, color, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_indices.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_indices.size() == 0) begin
            $display("nearest_palette_color_core verification clean");
        end else begin
            $display("nearest_palette_color_core verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("nearest_palette_color_core verification failed");
        $finish;
    end

endmodule
